[src/elcc_pkg.sv]
// Shared constants and scaling function for the electronic load controller.
package elcc_pkg;

    // ADC samples that make up one delivered sum
    localparam int unsigned SAMPLES_PER_SUM = 64;
    // Largest accepted current setpoint
    localparam int unsigned SETPOINT_MAX = 1000;
    localparam int unsigned SETPOINT_W = 10;

    // Charge rounding divisor (mA*ms to mA*s) and its half for rounding
    localparam int unsigned CHARGE_DIV = 1000;
    localparam int unsigned CHARGE_HALF = 500;
    localparam int unsigned DIV_W = 48;
    localparam int unsigned REM_W = $clog2(CHARGE_DIV);

    // Long division by the divisor over 16-bit digits, two steps per digit
    localparam int unsigned DIGIT_W = 16;
    localparam int unsigned DIV_STEPS = 2 * (DIV_W / DIGIT_W);
    localparam int unsigned DIV_STEP_W = $clog2(DIV_STEPS);
    localparam int unsigned PART_W = REM_W + DIGIT_W;

    // ceil(2^36 / 1000): exact digit quotient for any partial dividend below 2^26
    localparam int unsigned RECIP_SHIFT = 36;
    localparam int unsigned CHARGE_RECIP = 68719477;
    localparam int unsigned RECIP_W = 27;
    localparam int unsigned RECIP_PROD_W = PART_W + RECIP_W;

    localparam int unsigned PROD_W = 48;
    localparam int unsigned SCALE_W = 24;

    // Round a scaled ADC sum to whole units and saturate at 16 bits
    function automatic logic [15:0] scale_sum(input logic [PROD_W-1:0] prod);
        logic [SCALE_W:0] rounded;
        logic [SCALE_W:0] quo;
        begin
            rounded = {1'b0, prod[SCALE_W-1:0]} + (SCALE_W+1)'(SAMPLES_PER_SUM / 2);
            quo = rounded / (SCALE_W+1)'(SAMPLES_PER_SUM);
            if (quo > (SCALE_W+1)'(16'hFFFF))
                scale_sum = 16'hFFFF;
            else
                scale_sum = quo[15:0];
        end
    endfunction

endpackage

[src/elcc_div.sv]
// Divider by the charge rounding constant: digit-wise long division by reciprocal multiply.
module elcc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [elcc_pkg::DIV_W-1:0] dividend,
    output logic                       busy,
    output logic [31:0]                quotient
);
    import elcc_pkg::*;

    logic [DIV_W-1:0]        acc_reg, acc_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [DIGIT_W-1:0]      qd_reg, qd_next;
    logic [DIV_STEP_W-1:0]   cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic [PART_W-1:0]       part;
    logic [RECIP_PROD_W-1:0] recip_prod;
    logic [PART_W-1:0]       part_rem;

    // Form the partial dividend from the running remainder and the next digit
    assign part = {rem_reg, acc_reg[DIV_W-1 -: DIGIT_W]};
    assign recip_prod = RECIP_PROD_W'(part) * RECIP_PROD_W'(CHARGE_RECIP);
    assign part_rem = part - PART_W'(qd_reg) * PART_W'(CHARGE_DIV);

    // Even step: estimate the digit quotient; odd step: keep remainder, shift digit in
    always_comb
    begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        qd_next = qd_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            acc_next = dividend;
            rem_next = '0;
            qd_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!cnt_reg[0])
                qd_next = recip_prod[RECIP_SHIFT +: DIGIT_W];
            else
            begin
                rem_next = part_rem[REM_W-1:0];
                acc_next = {acc_reg[DIV_W-DIGIT_W-1:0], qd_reg};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_STEP_W'(DIV_STEPS - 1))
                busy_next = 1'b0;
        end
    end

    // Hold busy flag under reset, datapath without
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        qd_reg <= qd_next;
        cnt_reg <= cnt_next;
    end

    assign busy = busy_reg;
    assign quotient = acc_reg[31:0];

endmodule

[src/electronic_load_coulomb_controller_unit.sv]
// Electronic load controller core: microcoded sequencer over a shared multiplier.
//
//  channel   | direction | contents
//  s_axis    | in        | tuser: operation; tdata: setpoint, voltage_sum, current_sum
//  m_axis    | out       | tdata: drive level, on flag, mV, mA, charge, elapsed, cutoff
//  apb       | in/out    | mv_per_count @0x0, ma_per_count @0x4, cutoff_mv @0x8
//
// Tick, toggle and setpoint requests pass through fetch, one step and the result step.
// ADC deliveries add voltage and current scaling; while on, they also form the charge
// product, run the six-step digit divider rounding the increment and accumulate it.
// Reset clears pc, load state and result valid; registers return to 25, 10 and 1000.
// A stalled result holds the sequencer at its final step; one request is in work at a time.
module electronic_load_coulomb_controller_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [9:0] setpoint, [25:10] voltage_sum, [41:26] current_sum, [47:42] zero
    input  logic [47:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [9:0] drive_level, [10] output_on, [26:11] voltage_mv, [42:27] current_ma,
    // [74:43] charge_mas, [106:75] elapsed_ms, [107] cutoff_event, [111:108] zero
    output logic [111:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import elcc_pkg::*;

    typedef enum logic [3:0] {
        U_NOP, U_FETCH, U_TICK, U_TOGGLE, U_SETPT, U_MUL_V, U_SCALE_V,
        U_SCALE_C, U_MUL_Q, U_DIV_LOAD, U_ACCUM, U_CHECK
    } uop_t;

    typedef enum logic [2:0] {
        C_NEXT, C_GOTO, C_DISPATCH, C_IF_ON, C_DIV_WAIT, C_OUT_WAIT
    } cond_t;

    typedef enum logic [1:0] {
        REG_MV = 2'd0, REG_MA = 2'd1, REG_CUTOFF = 2'd2
    } reg_idx_t;

    typedef logic [3:0] pc_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        pc_t   target;
    } uword_t;

    localparam pc_t PC_FETCH = 4'd0;
    localparam pc_t PC_OPS   = 4'd1;
    localparam pc_t PC_CHECK = 4'd11;

    // Control store
    function automatic uword_t urom(input pc_t pc);
        begin
            unique case (pc)
                4'd0:    urom = '{U_FETCH,    C_DISPATCH, PC_OPS};
                4'd1:    urom = '{U_TICK,     C_GOTO,     PC_CHECK};
                4'd2:    urom = '{U_TOGGLE,   C_GOTO,     PC_CHECK};
                4'd3:    urom = '{U_SETPT,    C_GOTO,     PC_CHECK};
                4'd4:    urom = '{U_MUL_V,    C_NEXT,     PC_FETCH};
                4'd5:    urom = '{U_SCALE_V,  C_NEXT,     PC_FETCH};
                4'd6:    urom = '{U_SCALE_C,  C_IF_ON,    PC_CHECK};
                4'd7:    urom = '{U_MUL_Q,    C_NEXT,     PC_FETCH};
                4'd8:    urom = '{U_DIV_LOAD, C_NEXT,     PC_FETCH};
                4'd9:    urom = '{U_NOP,      C_DIV_WAIT, PC_FETCH};
                4'd10:   urom = '{U_ACCUM,    C_NEXT,     PC_FETCH};
                4'd11:   urom = '{U_CHECK,    C_OUT_WAIT, PC_FETCH};
                default: urom = '{U_NOP,      C_GOTO,     PC_FETCH};
            endcase
        end
    endfunction

    // Configuration registers
    logic [7:0]  mv_per_count_reg;
    logic [7:0]  ma_per_count_reg;
    logic [15:0] cutoff_mv_reg;
    reg_idx_t    cfg_idx;

    // Sequencer and architectural state
    pc_t                 pc_reg, pc_next;
    logic                load_on_reg, load_on_next;
    logic [SETPOINT_W-1:0] setpoint_reg, setpoint_next;
    logic [15:0]         last_v_reg, last_v_next;
    logic [15:0]         last_c_reg, last_c_next;
    logic [31:0]         charge_reg, charge_next;
    logic [31:0]         ms_reg, ms_next;
    logic [31:0]         last_upd_reg, last_upd_next;

    // Request latch and product register
    logic [SETPOINT_W-1:0] in_sp_reg, in_sp_next;
    logic [15:0]         in_vsum_reg, in_vsum_next;
    logic [15:0]         in_csum_reg, in_csum_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic [107:0]        out_reg, out_next;

    uword_t              uw;
    logic [31:0]         mul_a;
    logic [15:0]         mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic                out_free;
    logic                div_start;
    logic                div_busy;
    logic [31:0]         div_q;
    logic [SETPOINT_W-1:0] drive;

    elcc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg + DIV_W'(CHARGE_HALF)),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign uw = urom(pc_reg);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign div_start = (uw.uop == U_DIV_LOAD);
    assign s_axis_tready = (uw.uop == U_FETCH);

    // Select multiplier operands per step
    always_comb
    begin
        case (uw.uop)
            U_MUL_V:
            begin
                mul_a = {16'd0, in_vsum_reg};
                mul_b = {8'd0, mv_per_count_reg};
            end
            U_SCALE_V:
            begin
                mul_a = {16'd0, in_csum_reg};
                mul_b = {8'd0, ma_per_count_reg};
            end
            default:
            begin
                mul_a = ms_reg - last_upd_reg;
                mul_b = last_c_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Execute the current control word and pick the next step
    always_comb
    begin
        pc_next = pc_reg;
        load_on_next = load_on_reg;
        setpoint_next = setpoint_reg;
        last_v_next = last_v_reg;
        last_c_next = last_c_reg;
        charge_next = charge_reg;
        ms_next = ms_reg;
        last_upd_next = last_upd_reg;
        in_sp_next = in_sp_reg;
        in_vsum_next = in_vsum_reg;
        in_csum_next = in_csum_reg;
        prod_next = prod_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_next = out_reg;
        drive = '0;

        case (uw.uop)
            U_FETCH:
            begin
                if (s_axis_tvalid)
                begin
                    in_sp_next = s_axis_tdata[9:0];
                    in_vsum_next = s_axis_tdata[25:10];
                    in_csum_next = s_axis_tdata[41:26];
                end
            end
            U_TICK:
                ms_next = ms_reg + 32'd1;
            U_TOGGLE:
            begin
                if (load_on_reg)
                    load_on_next = 1'b0;
                else
                begin
                    charge_next = '0;
                    last_upd_next = '0;
                    ms_next = '0;
                    load_on_next = 1'b1;
                end
            end
            U_SETPT:
            begin
                if (in_sp_reg > SETPOINT_W'(SETPOINT_MAX))
                    setpoint_next = SETPOINT_W'(SETPOINT_MAX);
                else
                    setpoint_next = in_sp_reg;
            end
            U_MUL_V:
                prod_next = mul_p;
            U_SCALE_V:
            begin
                last_v_next = scale_sum(prod_reg);
                prod_next = mul_p;
            end
            U_SCALE_C:
                last_c_next = scale_sum(prod_reg);
            U_MUL_Q:
            begin
                prod_next = mul_p;
                last_upd_next = ms_reg;
            end
            U_ACCUM:
                charge_next = charge_reg + div_q;
            U_CHECK:
            begin
                if (out_free)
                begin
                    load_on_next = load_on_reg && !(cutoff_mv_reg > last_v_reg);
                    drive = load_on_next ? setpoint_reg : '0;
                    out_valid_next = 1'b1;
                    out_next = {load_on_reg && !load_on_next, last_upd_reg, charge_reg,
                                last_c_reg, last_v_reg, load_on_next, drive};
                end
            end
            default:
            begin
            end
        endcase

        // Advance the step counter
        case (uw.cond)
            C_NEXT:     pc_next = pc_reg + 4'd1;
            C_GOTO:     pc_next = uw.target;
            C_DISPATCH: pc_next = s_axis_tvalid ? uw.target + {2'd0, s_axis_tuser} : pc_reg;
            C_IF_ON:    pc_next = load_on_reg ? pc_reg + 4'd1 : uw.target;
            C_DIV_WAIT: pc_next = div_busy ? pc_reg : pc_reg + 4'd1;
            C_OUT_WAIT: pc_next = out_free ? uw.target : pc_reg;
            default:    pc_next = PC_FETCH;
        endcase
    end

    // Hold sequencer, state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_FETCH;
            load_on_reg <= 1'b0;
            setpoint_reg <= '0;
            last_v_reg <= '0;
            last_c_reg <= '0;
            charge_reg <= '0;
            ms_reg <= '0;
            last_upd_reg <= '0;
            out_valid_reg <= 1'b0;
            mv_per_count_reg <= 8'd25;
            ma_per_count_reg <= 8'd10;
            cutoff_mv_reg <= 16'd1000;
        end
        else
        begin
            pc_reg <= pc_next;
            load_on_reg <= load_on_next;
            setpoint_reg <= setpoint_next;
            last_v_reg <= last_v_next;
            last_c_reg <= last_c_next;
            charge_reg <= charge_next;
            ms_reg <= ms_next;
            last_upd_reg <= last_upd_next;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite && pready)
            begin
                unique case (cfg_idx)
                    REG_MV:     mv_per_count_reg <= pwdata[7:0];
                    REG_MA:     ma_per_count_reg <= pwdata[7:0];
                    REG_CUTOFF: cutoff_mv_reg <= pwdata[15:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Hold request payload and result payload
    always_ff @(posedge clk)
    begin
        in_sp_reg <= in_sp_next;
        in_vsum_reg <= in_vsum_next;
        in_csum_reg <= in_csum_next;
        prod_reg <= prod_next;
        out_reg <= out_next;
    end

    // Decode register reads
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;

    always_comb
    begin
        unique case (cfg_idx)
            REG_MV:     prdata = {24'd0, mv_per_count_reg};
            REG_MA:     prdata = {24'd0, ma_per_count_reg};
            REG_CUTOFF: prdata = {16'd0, cutoff_mv_reg};
            default:    prdata = '0;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {4'd0, out_reg};

endmodule

[sim/tb_top.sv]
// Testbench for the load controller core: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
    import elcc_pkg::*;

    // Request codes carried on s_axis_tuser
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_TOGGLE   = 2'd1;
    localparam logic [1:0] OP_SETPOINT = 2'd2;
    localparam logic [1:0] OP_ADC      = 2'd3;

    // Register byte addresses; the last one lies beyond the register list
    localparam logic [3:0] ADDR_MV_PER_COUNT = 4'h0;
    localparam logic [3:0] ADDR_MA_PER_COUNT = 4'h4;
    localparam logic [3:0] ADDR_CUTOFF_MV    = 4'h8;
    localparam logic [3:0] ADDR_UNUSED       = 4'hC;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned DRAIN_CYCLES  = 80;
    localparam int unsigned PHASE_ITEMS   = 160;
    localparam int unsigned PHASE_COUNT   = 8;

    // Result fields, drive_level in the lowest bits
    typedef struct packed {
        logic        cutoff_event;
        logic [31:0] elapsed_ms;
        logic [31:0] charge_mas;
        logic [15:0] current_ma;
        logic [15:0] voltage_mv;
        logic        output_on;
        logic [9:0]  drive_level;
    } load_result_t;

    class load_scoreboard;
        logic [7:0]  mv_per_count;
        logic [7:0]  ma_per_count;
        logic [15:0] cutoff_mv;
        bit          load_on;
        logic [9:0]  setpoint;
        logic [15:0] voltage;
        logic [15:0] current;
        logic [31:0] charge;
        logic [31:0] ms_count;
        logic [31:0] update_ms;
        load_result_t pending[$];
        int unsigned errors;
        int unsigned results;
        int unsigned cutoffs;
        int unsigned charge_updates;

        function new();
            mv_per_count = 8'd25;
            ma_per_count = 8'd10;
            cutoff_mv = 16'd1000;
            load_on = 1'b0;
            setpoint = '0;
            voltage = '0;
            current = '0;
            charge = '0;
            ms_count = '0;
            update_ms = '0;
            errors = 0;
            results = 0;
            cutoffs = 0;
            charge_updates = 0;
        endfunction

        function void write_register(logic [3:0] addr, logic [31:0] value);
            case (addr)
                ADDR_MV_PER_COUNT: mv_per_count = value[7:0];
                ADDR_MA_PER_COUNT: ma_per_count = value[7:0];
                ADDR_CUTOFF_MV:    cutoff_mv = value[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] register_value(logic [3:0] addr);
            case (addr)
                ADDR_MV_PER_COUNT: return {24'd0, mv_per_count};
                ADDR_MA_PER_COUNT: return {24'd0, ma_per_count};
                default:           return {16'd0, cutoff_mv};
            endcase
        endfunction

        // Round an ADC sum to whole units and saturate at 16 bits
        function logic [15:0] to_units(logic [15:0] sum, logic [7:0] per_count);
            logic [31:0] v;
            v = (32'(sum) * 32'(per_count) + 32'(SAMPLES_PER_SUM / 2)) / 32'(SAMPLES_PER_SUM);
            return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
        endfunction

        // Advance the load state for one accepted request and queue its result
        function void note_request(logic [1:0] op, logic [9:0] sp, logic [15:0] vsum,
                                   logic [15:0] csum);
            load_result_t r;
            logic [31:0] passed;
            logic [63:0] add;
            bit cut;
            cut = 1'b0;
            case (op)
                OP_TICK: ms_count = ms_count + 32'd1;
                OP_TOGGLE:
                begin
                    if (load_on)
                        load_on = 1'b0;
                    else
                    begin
                        charge = '0;
                        update_ms = '0;
                        ms_count = '0;
                        load_on = 1'b1;
                    end
                end
                OP_SETPOINT: setpoint = (sp > 10'(SETPOINT_MAX)) ? 10'(SETPOINT_MAX) : sp;
                default:
                begin
                    voltage = to_units(vsum, mv_per_count);
                    current = to_units(csum, ma_per_count);
                    if (load_on)
                    begin
                        passed = ms_count - update_ms;
                        update_ms = ms_count;
                        add = (64'(passed) * 64'(current) + 64'(CHARGE_HALF)) / 64'(CHARGE_DIV);
                        charge = charge + add[31:0];
                        charge_updates++;
                    end
                end
            endcase
            // Undervoltage switch-off applies after every request
            if (load_on && cutoff_mv > voltage)
            begin
                load_on = 1'b0;
                cut = 1'b1;
                cutoffs++;
            end
            r.drive_level = load_on ? setpoint : 10'd0;
            r.output_on = load_on;
            r.voltage_mv = voltage;
            r.current_ma = current;
            r.charge_mas = charge;
            r.elapsed_ms = update_ms;
            r.cutoff_event = cut;
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
            if (expected !== actual)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, expected, actual);
            end
        endfunction

        // Compare one accepted result against the oldest expectation
        function void check_result(logic [111:0] data);
            load_result_t act;
            load_result_t exp;
            act = load_result_t'(data[107:0]);
            results++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                return;
            end
            exp = pending.pop_front();
            compare_field("drive_level", 32'(exp.drive_level), 32'(act.drive_level));
            compare_field("output_on", 32'(exp.output_on), 32'(act.output_on));
            compare_field("voltage_mv", 32'(exp.voltage_mv), 32'(act.voltage_mv));
            compare_field("current_ma", 32'(exp.current_ma), 32'(act.current_ma));
            compare_field("charge_mas", exp.charge_mas, act.charge_mas);
            compare_field("elapsed_ms", exp.elapsed_ms, act.elapsed_ms);
            compare_field("cutoff_event", 32'(exp.cutoff_event), 32'(act.cutoff_event));
        endfunction
    endclass

    logic         clk;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = OP_TICK;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    load_scoreboard sb;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;

    electronic_load_coulomb_controller_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // At random hold off a request, then present it until it is taken
    task automatic send_request(input logic [1:0] op, input logic [9:0] sp,
                                input logic [15:0] vsum, input logic [15:0] csum);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {6'd0, csum, vsum, sp};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(op, sp, vsum, csum);
    endtask

    // Run one setup and access pair, then idle the bus
    task automatic apb_transfer(input bit wr, input logic [3:0] addr, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write a register, then read it back where it exists
    task automatic write_config(input logic [3:0] addr, input logic [31:0] value);
        logic [31:0] rdata;
        apb_transfer(1'b1, addr, value, rdata);
        sb.write_register(addr, value);
        if (addr != ADDR_UNUSED)
        begin
            apb_transfer(1'b0, addr, '0, rdata);
            if (rdata !== sb.register_value(addr))
            begin
                sb.errors++;
                $display("%0t: register read at %h mismatch, expected %0d, actual %0d",
                         $time, addr, sb.register_value(addr), rdata);
            end
        end
    endtask

    // Drop the request side and wait until the block has gone idle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random sequences: mostly ticks and ADC deliveries with healthy voltage
    task automatic run_random(input int unsigned count);
        int unsigned pick;
        logic [15:0] vsum;
        for (int unsigned i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 15)
                vsum = 16'($urandom_range(0, 65535));
            else
                vsum = 16'($urandom_range(32768, 65535));
            if (pick < (sb.load_on ? 3 : 12))
                send_request(OP_TOGGLE, 10'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 22)
                send_request(OP_SETPOINT, 10'($urandom_range(0, 1023)), 16'($urandom),
                             16'($urandom));
            else if (pick < 55)
                send_request(OP_ADC, 10'($urandom), vsum, 16'($urandom_range(0, 65535)));
            else
                send_request(OP_TICK, 10'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a write past the register list must change nothing
        write_config(ADDR_UNUSED, 32'hFFFF_FFFF);
        send_request(OP_TICK, 10'd0, 16'd0, 16'd0);
        // Turn on with no voltage measured: immediate switch-off
        send_request(OP_TOGGLE, 10'd0, 16'd0, 16'd0);
        send_request(OP_ADC, 10'd0, 16'hFFFF, 16'hFFFF);
        send_request(OP_SETPOINT, 10'd1023, 16'd0, 16'd0);
        send_request(OP_SETPOINT, 10'd1001, 16'd0, 16'd0);
        send_request(OP_SETPOINT, 10'd0, 16'd0, 16'd0);
        send_request(OP_SETPOINT, 10'd1000, 16'd0, 16'd0);
        send_request(OP_TOGGLE, 10'd0, 16'd0, 16'd0);
        send_request(OP_TICK, 10'd0, 16'd0, 16'd0);
        send_request(OP_TICK, 10'd0, 16'd0, 16'd0);
        send_request(OP_TICK, 10'd0, 16'd0, 16'd0);
        send_request(OP_ADC, 10'd0, 16'hFFFF, 16'hFFFF);
        send_request(OP_SETPOINT, 10'd512, 16'd0, 16'd0);
        send_request(OP_TICK, 10'd0, 16'd0, 16'd0);
        // Voltage collapse while on
        send_request(OP_ADC, 10'd0, 16'd0, 16'd0);
        send_request(OP_ADC, 10'd0, 16'd2559, 16'd1);
        send_request(OP_TOGGLE, 10'd0, 16'd0, 16'd0);
        send_request(OP_TICK, 10'd0, 16'd0, 16'd0);
        // Exactly at the cutoff stays on; one count below switches off
        send_request(OP_ADC, 10'd0, 16'd2559, 16'd4000);
        send_request(OP_TICK, 10'd0, 16'd0, 16'd0);
        send_request(OP_ADC, 10'd0, 16'd2558, 16'd4000);
        send_request(OP_TOGGLE, 10'd0, 16'd0, 16'd0);
        send_request(OP_TOGGLE, 10'd0, 16'd0, 16'd0);
        drain();
        // Saturation of both scaled values
        write_config(ADDR_MV_PER_COUNT, 32'd255);
        write_config(ADDR_MA_PER_COUNT, 32'd255);
        send_request(OP_ADC, 10'd0, 16'hFFFF, 16'hFFFF);
        send_request(OP_ADC, 10'd0, 16'd16448, 16'd16447);
        drain();

        // Random phases over several register settings and idling patterns
        for (int unsigned p = 0; p < PHASE_COUNT; p++)
        begin
            case (p % 5)
                0:
                begin
                    write_config(ADDR_MV_PER_COUNT, 32'd25);
                    write_config(ADDR_MA_PER_COUNT, 32'd10);
                    write_config(ADDR_CUTOFF_MV, 32'd1000);
                end
                1:
                begin
                    write_config(ADDR_MV_PER_COUNT, 32'd255);
                    write_config(ADDR_MA_PER_COUNT, 32'd255);
                    write_config(ADDR_CUTOFF_MV, 32'd65535);
                end
                2:
                begin
                    write_config(ADDR_MV_PER_COUNT, 32'd0);
                    write_config(ADDR_MA_PER_COUNT, 32'd0);
                    write_config(ADDR_CUTOFF_MV, 32'd0);
                end
                3:
                begin
                    write_config(ADDR_MV_PER_COUNT, 32'd1);
                    write_config(ADDR_MA_PER_COUNT, 32'd1);
                    write_config(ADDR_CUTOFF_MV, 32'd1);
                end
                default:
                begin
                    write_config(ADDR_MV_PER_COUNT, $urandom_range(0, 255));
                    write_config(ADDR_MA_PER_COUNT, $urandom_range(0, 255));
                    write_config(ADDR_CUTOFF_MV, $urandom_range(0, 16383));
                end
            endcase
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 63;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 63;
                end
                default:
                begin
                    send_idle_pct = 36;
                    stall_pct = 36;
                end
            endcase
            run_random(PHASE_ITEMS);
            drain();
        end

        $display("Run covered %0d results over %0d register settings and four idling patterns,",
                 sb.results, PHASE_COUNT + 2);
        $display("with %0d charge updates and %0d undervoltage switch-offs.",
                 sb.charge_updates, sb.cutoffs);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
